/* rtl/cde_pkg.sv */
`default_nettype none

package cde_pkg;

    localparam int DEPTH = 256;
    localparam int DW    = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ       = 3'd4,
        OP_CLEAR      = 3'd5,
        OP_ORDERED    = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_WALK
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] value;
        logic [7:0]         index;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [8:0]         length;
        t_status            status;
        logic               ordered;
    } t_rsp;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
        return head + pos[AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/cde_ram.sv */
`default_nettype none

module cde_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/circular_deque_engine.sv */
`default_nettype none

// A double-ended queue of cde_pkg::DEPTH signed elements kept in one
// synchronous memory addressed through a head pointer and an element count.
// A command beat is taken at a rising edge where start is high and busy is
// low; busy stays high while the command is being executed.
// Each command produces one result beat: o_valid is high for exactly one
// cycle with o_rsp, and the receiver must take it then.
// Push, pop, clear, unused opcodes, a read beyond the length and an ordered
// check on fewer than two elements execute in the EXEC state against the
// memory and pointers, and their result is then registered and presented.
// A read within the length passes through the EXEC and RDWAIT states, as the
// memory output is registered.
// An ordered check on two or more elements reads the elements one by one in
// the WALK state, with one memory read per cycle; it stops at the tail or at
// the first element that is smaller than its predecessor.
// A new command may be accepted in the cycle where the previous result is
// presented, but not while the previous command is still executing.
// Synchronous reset empties the queue and moves the head to slot zero.
// The memory contents are not cleared by reset or by a clear command.
module circular_deque_engine (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire cde_pkg::t_cmd i_cmd,
    output logic               o_valid,
    output cde_pkg::t_rsp      o_rsp
);

    localparam int DW = cde_pkg::DW;
    localparam int AW = cde_pkg::AW;
    localparam int CW = cde_pkg::CW;

    cde_pkg::t_state r_state, n_state;
    cde_pkg::t_cmd   r_cmd;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_first, n_first;
    logic [DW-1:0]   r_prev, n_prev;
    logic            r_valid, n_valid;
    cde_pkg::t_rsp   r_rsp, n_rsp;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [DW-1:0]   mem_rdata;

    logic            accept;
    logic            full;
    logic            empty;
    logic            read_ok;
    logic            walk_start;
    logic            walk_fail;
    logic            walk_end;

    assign accept     = start && !busy;
    assign full       = (r_count == CW'(cde_pkg::DEPTH));
    assign empty      = (r_count == '0);
    assign read_ok    = (CW'(r_cmd.index) < r_count);
    assign walk_start = (r_count > CW'(1));
    assign walk_fail  = !r_first && ($signed(r_prev) > $signed(mem_rdata));
    assign walk_end   = walk_fail || (r_pos == r_count);

    cde_ram #(
        .DEPTH (cde_pkg::DEPTH),
        .WIDTH (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_cmd.value[DW-1:0]),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            cde_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = cde_pkg::S_EXEC;
                end
            end
            cde_pkg::S_EXEC: begin
                if (r_cmd.opcode == cde_pkg::OP_READ && read_ok) begin
                    n_state = cde_pkg::S_RDWAIT;
                end else if (r_cmd.opcode == cde_pkg::OP_ORDERED && walk_start) begin
                    n_state = cde_pkg::S_WALK;
                end else begin
                    n_state = cde_pkg::S_IDLE;
                end
            end
            cde_pkg::S_RDWAIT: begin
                n_state = cde_pkg::S_IDLE;
            end
            cde_pkg::S_WALK: begin
                if (walk_end) begin
                    n_state = cde_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cde_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_first   = r_first;
        n_prev    = r_prev;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = cde_pkg::f_slot(r_head, r_count);
        mem_re    = 1'b0;
        mem_raddr = r_head;
        case (r_state)
            cde_pkg::S_EXEC: begin
                n_valid           = 1'b1;
                n_rsp.read_data   = '0;
                n_rsp.status      = cde_pkg::ST_OK;
                n_rsp.ordered     = 1'b0;
                case (r_cmd.opcode)
                    cde_pkg::OP_PUSH_BACK: begin
                        if (full) begin
                            n_rsp.status = cde_pkg::ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    cde_pkg::OP_PUSH_FRONT: begin
                        if (full) begin
                            n_rsp.status = cde_pkg::ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_head - AW'(1);
                            n_head    = r_head - AW'(1);
                            n_count   = r_count + CW'(1);
                        end
                    end
                    cde_pkg::OP_POP_BACK: begin
                        if (empty) begin
                            n_rsp.status = cde_pkg::ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    cde_pkg::OP_POP_FRONT: begin
                        if (empty) begin
                            n_rsp.status = cde_pkg::ST_EMPTY;
                        end else begin
                            n_head  = r_head + AW'(1);
                            n_count = r_count - CW'(1);
                        end
                    end
                    cde_pkg::OP_READ: begin
                        if (read_ok) begin
                            n_valid   = 1'b0;
                            mem_re    = 1'b1;
                            mem_raddr = cde_pkg::f_slot(r_head, CW'(r_cmd.index));
                        end else begin
                            n_rsp.status = cde_pkg::ST_RANGE;
                        end
                    end
                    cde_pkg::OP_CLEAR: begin
                        n_head  = '0;
                        n_count = '0;
                    end
                    cde_pkg::OP_ORDERED: begin
                        if (walk_start) begin
                            n_valid   = 1'b0;
                            mem_re    = 1'b1;
                            mem_raddr = r_head;
                            n_pos     = CW'(1);
                            n_first   = 1'b1;
                        end else begin
                            n_rsp.ordered = 1'b1;
                        end
                    end
                    default: begin
                        n_rsp.status = cde_pkg::ST_OK;
                    end
                endcase
                n_rsp.length = 9'(n_count);
            end
            cde_pkg::S_RDWAIT: begin
                n_valid         = 1'b1;
                n_rsp.read_data = 32'($signed(mem_rdata));
                n_rsp.length    = 9'(r_count);
                n_rsp.status    = cde_pkg::ST_OK;
                n_rsp.ordered   = 1'b0;
            end
            cde_pkg::S_WALK: begin
                n_prev  = mem_rdata;
                n_first = 1'b0;
                if (walk_end) begin
                    n_valid         = 1'b1;
                    n_rsp.read_data = '0;
                    n_rsp.length    = 9'(r_count);
                    n_rsp.status    = cde_pkg::ST_OK;
                    n_rsp.ordered   = !walk_fail;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = cde_pkg::f_slot(r_head, r_pos);
                    n_pos     = r_pos + CW'(1);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cde_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_pos   <= n_pos;
        r_first <= n_first;
        r_prev  <= n_prev;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != cde_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(cde_pkg::DEPTH))
        else $error("element count exceeds capacity");

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != cde_pkg::S_IDLE))
        else $error("result beat without a command in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == cde_pkg::S_EXEC))
        else $error("accepted command did not enter execution");

    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cde_pkg::S_WALK) |-> (r_pos >= CW'(1) && r_pos <= r_count))
        else $error("ordered walk position outside the live region");

    a_walk_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cde_pkg::S_WALK || r_state == cde_pkg::S_RDWAIT) |-> !mem_we)
        else $error("memory write during a read sequence");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam cde_pkg::t_opcode OP_UNUSED = cde_pkg::t_opcode'(3'd7);

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    cde_pkg::t_cmd  i_cmd;
    logic           o_valid;
    cde_pkg::t_rsp  o_rsp;

    logic signed [31:0] model_mem [cde_pkg::DEPTH];
    logic [7:0]         model_head;
    logic [8:0]         model_count;

    cde_pkg::t_rsp expected_rsp [$];
    int   n_errors;
    int   n_beats;
    bit   idle_on;

    circular_deque_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic cde_pkg::t_rsp predict_deque(input cde_pkg::t_cmd cmd);
        cde_pkg::t_rsp r;
        logic [7:0]    slot;
        logic [7:0]    prev;
        r = '0;
        r.status = cde_pkg::ST_OK;
        case (cmd.opcode)
            cde_pkg::OP_PUSH_BACK: begin
                if (model_count == cde_pkg::DEPTH) begin
                    r.status = cde_pkg::ST_FULL;
                end else begin
                    slot = model_head + model_count[7:0];
                    model_mem[slot] = cmd.value;
                    model_count = model_count + 1'b1;
                end
            end
            cde_pkg::OP_PUSH_FRONT: begin
                if (model_count == cde_pkg::DEPTH) begin
                    r.status = cde_pkg::ST_FULL;
                end else begin
                    model_head = model_head - 8'd1;
                    model_mem[model_head] = cmd.value;
                    model_count = model_count + 1'b1;
                end
            end
            cde_pkg::OP_POP_BACK: begin
                if (model_count == 0) r.status = cde_pkg::ST_EMPTY;
                else model_count = model_count - 1'b1;
            end
            cde_pkg::OP_POP_FRONT: begin
                if (model_count == 0) begin
                    r.status = cde_pkg::ST_EMPTY;
                end else begin
                    model_head = model_head + 8'd1;
                    model_count = model_count - 1'b1;
                end
            end
            cde_pkg::OP_READ: begin
                if ({1'b0, cmd.index} >= model_count) begin
                    r.status = cde_pkg::ST_RANGE;
                end else begin
                    slot = model_head + cmd.index;
                    r.read_data = model_mem[slot];
                end
            end
            cde_pkg::OP_CLEAR: begin
                model_head = '0;
                model_count = '0;
            end
            cde_pkg::OP_ORDERED: begin
                r.ordered = 1'b1;
                for (int i = 1; i < model_count; i++) begin
                    prev = model_head + 8'(i - 1);
                    slot = model_head + 8'(i);
                    if (model_mem[prev] > model_mem[slot]) r.ordered = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.length = model_count;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input cde_pkg::t_opcode op, input logic [31:0] val,
                            input logic [7:0] idx);
        cde_pkg::t_cmd cmd;
        cmd.opcode = op;
        cmd.value  = val;
        cmd.index  = idx;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_rsp.push_back(predict_deque(cmd));
        n_beats++;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random_op();
        int unsigned pick;
        logic [7:0]  idx;
        pick = $urandom_range(0, 99);
        idx  = 8'($urandom_range(0, 255));
        if (model_count != 0 && $urandom_range(0, 3) != 0) begin
            idx = 8'($urandom_range(0, model_count - 1));
        end
        if (pick < 25)      send_cmd(cde_pkg::OP_PUSH_BACK, pick_value(), idx);
        else if (pick < 40) send_cmd(cde_pkg::OP_PUSH_FRONT, pick_value(), idx);
        else if (pick < 50) send_cmd(cde_pkg::OP_POP_BACK, $urandom, idx);
        else if (pick < 60) send_cmd(cde_pkg::OP_POP_FRONT, $urandom, idx);
        else if (pick < 80) send_cmd(cde_pkg::OP_READ, $urandom, idx);
        else if (pick < 90) send_cmd(cde_pkg::OP_ORDERED, $urandom, idx);
        else if (pick < 96) send_cmd(cde_pkg::OP_CLEAR, $urandom, idx);
        else                send_cmd(OP_UNUSED, $urandom, idx);
    endtask

    task automatic test_empty_cases();
        idle_on = 1'b1;
        send_cmd(cde_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 8'hFF);
        send_cmd(cde_pkg::OP_POP_FRONT, 32'h0, 8'h0);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_READ, 32'hFFFF_FFFF, 8'd255);
        send_cmd(cde_pkg::OP_ORDERED, 32'h0, 8'd0);
        send_cmd(OP_UNUSED, 32'hA5A5_5A5A, 8'h5A);
        send_cmd(cde_pkg::OP_CLEAR, 32'h5A5A_A5A5, 8'hA5);
    endtask

    task automatic test_extremes();
        idle_on = 1'b1;
        send_cmd(cde_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 8'd0);
        send_cmd(cde_pkg::OP_PUSH_BACK, 32'h8000_0000, 8'd0);
        send_cmd(cde_pkg::OP_PUSH_FRONT, 32'h0000_0000, 8'd0);
        send_cmd(cde_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 8'd0);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd1);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd2);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd3);
        send_cmd(cde_pkg::OP_READ, 32'h0, 8'd4);
        send_cmd(cde_pkg::OP_ORDERED, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_POP_BACK, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_ORDERED, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_POP_FRONT, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_POP_FRONT, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_ORDERED, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_POP_BACK, 32'h0, 8'd0);
        send_cmd(cde_pkg::OP_POP_BACK, 32'h0, 8'd0);
    endtask

    task automatic test_full_store();
        idle_on = 1'b1;
        send_cmd(cde_pkg::OP_CLEAR, $urandom, 8'($urandom));
        for (int k = 0; k < cde_pkg::DEPTH; k++) begin
            send_cmd(cde_pkg::OP_PUSH_BACK, 32'(k * 16_000_000) - 32'sd2_000_000_000,
                     8'($urandom));
        end
        send_cmd(cde_pkg::OP_PUSH_BACK, pick_value(), 8'($urandom));
        send_cmd(cde_pkg::OP_PUSH_FRONT, pick_value(), 8'($urandom));
        send_cmd(cde_pkg::OP_READ, $urandom, 8'd255);
        send_cmd(cde_pkg::OP_READ, $urandom, 8'd0);
        send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
        send_cmd(cde_pkg::OP_POP_FRONT, $urandom, 8'($urandom));
        send_cmd(cde_pkg::OP_PUSH_BACK, 32'h8000_0000, 8'($urandom));
        send_cmd(cde_pkg::OP_READ, $urandom, 8'd255);
        send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
        send_cmd(cde_pkg::OP_CLEAR, $urandom, 8'($urandom));
        for (int k = 0; k < cde_pkg::DEPTH; k++) begin
            send_cmd(k[0] ? cde_pkg::OP_PUSH_FRONT : cde_pkg::OP_PUSH_BACK, pick_value(),
                     8'($urandom));
        end
        send_cmd(cde_pkg::OP_PUSH_FRONT, pick_value(), 8'($urandom));
        send_cmd(cde_pkg::OP_READ, $urandom, 8'd128);
        send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
    endtask

    task automatic sorted_run();
        int     len;
        longint cur;
        longint lo;
        send_cmd(cde_pkg::OP_CLEAR, $urandom, 8'($urandom));
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250) : $urandom_range(2, 30);
        cur = longint'($signed(pick_value()));
        lo  = cur;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 29) == 0 && cur > -64'sd2147483648) begin
                send_cmd(cde_pkg::OP_PUSH_BACK, 32'(cur - 1), 8'($urandom));
            end
            send_cmd(cde_pkg::OP_PUSH_BACK, cur[31:0], 8'($urandom));
            if ($urandom_range(0, 3) != 0) cur = cur + $urandom_range(1, 1 << 20);
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        end
        send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
        repeat ($urandom_range(1, 5)) begin
            lo = lo - $urandom_range(0, 1000);
            if (lo < -64'sd2147483648) lo = -64'sd2147483648;
            send_cmd(cde_pkg::OP_PUSH_FRONT, lo[31:0], 8'($urandom));
        end
        send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
        if ($urandom_range(0, 1) == 0) begin
            send_cmd(cde_pkg::OP_PUSH_BACK, pick_value(), 8'($urandom));
            send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
        end
    endtask

    task automatic test_random_mix();
        int stop_at;
        stop_at = n_beats + 150;
        while (n_beats < stop_at) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                6: sorted_run();
                7: begin
                    repeat ($urandom_range(10, 60)) begin
                        send_cmd($urandom_range(0, 1) ? cde_pkg::OP_PUSH_BACK
                                                      : cde_pkg::OP_PUSH_FRONT,
                                 pick_value(), 8'($urandom));
                    end
                end
                8: begin
                    repeat ($urandom_range(10, 60)) begin
                        send_cmd($urandom_range(0, 1) ? cde_pkg::OP_POP_BACK
                                                      : cde_pkg::OP_POP_FRONT,
                                 $urandom, 8'($urandom));
                    end
                    send_cmd(cde_pkg::OP_ORDERED, $urandom, 8'($urandom));
                end
                9: begin
                    for (int k = 0; k <= model_count; k++) begin
                        send_cmd(cde_pkg::OP_READ, $urandom, 8'(k));
                    end
                end
                default: repeat ($urandom_range(5, 30)) send_random_op();
            endcase
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (100) send_random_op();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && $isunknown(o_valid)) begin
            $error("o_valid: expected a known value, actual %b", o_valid);
            n_errors++;
        end else if (i_rst_n && o_valid) begin
            if (expected_rsp.size() == 0) begin
                $error("o_valid: expected no result, actual result %p", o_rsp);
                n_errors++;
            end else begin
                cde_pkg::t_rsp exp_rsp;
                exp_rsp = expected_rsp.pop_front();
                if (o_rsp.read_data !== exp_rsp.read_data) begin
                    $error("read_data: expected %0d, actual %0d",
                           exp_rsp.read_data, o_rsp.read_data);
                    n_errors++;
                end
                if (o_rsp.length !== exp_rsp.length) begin
                    $error("length: expected %0d, actual %0d", exp_rsp.length, o_rsp.length);
                    n_errors++;
                end
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status, o_rsp.status);
                    n_errors++;
                end
                if (o_rsp.ordered !== exp_rsp.ordered) begin
                    $error("ordered: expected %0d, actual %0d", exp_rsp.ordered, o_rsp.ordered);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        n_errors    = 0;
        n_beats     = 0;
        idle_on     = 1'b0;
        model_head  = '0;
        model_count = '0;
        for (int k = 0; k < cde_pkg::DEPTH; k++) model_mem[k] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_cases();
        test_extremes();
        test_full_store();
        test_random_mix();
        test_back_to_back();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
